[hdl/response_string_matcher_with_timeout_defines.svh]
// -----------------------------------------------------------------------------
// Response string matcher assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during rst_ni low.
// -----------------------------------------------------------------------------
`ifndef RESPONSE_STRING_MATCHER_WITH_TIMEOUT_DEFINES_SVH
`define RESPONSE_STRING_MATCHER_WITH_TIMEOUT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
// Plain invariant.
`define RSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define RSM_ASSERT_IMPL(lbl, ante, cons, msg)
`define RSM_ASSERT_NEXT(lbl, ante, cons, msg)
`define RSM_ASSERT(lbl, prop, msg)
`endif

`endif

[hdl/rsm_pkg.sv]
// -----------------------------------------------------------------------------
// Response string matcher package
// Shared constants, codes and the configuration record.
// -----------------------------------------------------------------------------
package rsm_pkg;

  localparam int MAX_PATTERN_CHARS = 16;
  // The pattern registers hold sixteen characters in total.
  localparam int NUM_CHARS  = 16;
  localparam int CHAR_IDX_W = 4;
  localparam int LEN_W      = $clog2(MAX_PATTERN_CHARS + 1);
  localparam int TICK_W     = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_WAITING = 2'd0,
    ST_FOUND   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_LENGTH   = 2'd2,
    REG_TIMEOUT  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [NUM_CHARS-1:0][7:0] chars;
    logic [4:0]                length;
    logic [TICK_W-1:0]         timeout;
  } rsm_cfg_t;

  // A length of zero acts as one; lengths above the maximum are clipped.
  function automatic logic [LEN_W-1:0] effective_length(input logic [4:0] len);
    logic [LEN_W-1:0] n;
    if (len == 5'd0) begin
      n = LEN_W'(1);
    end else if (32'(len) > MAX_PATTERN_CHARS) begin
      n = LEN_W'(MAX_PATTERN_CHARS);
    end else begin
      n = LEN_W'(len);
    end
    return n;
  endfunction

endpackage

[hdl/rsm_if.sv]
// -----------------------------------------------------------------------------
// Response string matcher channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// -----------------------------------------------------------------------------
interface rsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface rsm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] match_position;

  modport source (output valid, output status, output match_position, input ready);
  modport sink (input valid, input status, input match_position, output ready);
endinterface

interface rsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

[hdl/rsm_cfg_regs.sv]
// -----------------------------------------------------------------------------
// Response string matcher configuration registers
// Decodes configuration write transactions into the pattern, length and timeout.
// -----------------------------------------------------------------------------
module rsm_cfg_regs
  import rsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rsm_cfg_if.sink   cfg_i,
  output rsm_cfg_t  cfg_o
);

  rsm_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chars   <= '0;
      cfg_q.length  <= 5'd1;
      cfg_q.timeout <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_PAT_LOW:  cfg_q.chars[7:0]  <= cfg_i.data;
        REG_PAT_HIGH: cfg_q.chars[15:8] <= cfg_i.data;
        REG_LENGTH:   cfg_q.length      <= cfg_i.data[4:0];
        REG_TIMEOUT:  cfg_q.timeout     <= cfg_i.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/response_string_matcher_with_timeout.sv]
// -----------------------------------------------------------------------------
// Response string matcher with timeout
// Streaming match of a configured response string against received bytes,
// bounded by a millisecond tick count.
// -----------------------------------------------------------------------------
// The block takes one transaction per clock cycle and returns exactly one
// result per transaction, in the cycle after it is accepted. Each transaction is
// a received byte, a tick or a restart; the match position, the elapsed tick
// count and the status are updated in that same cycle and the new status and
// position are loaded into the result register. The input stays ready while
// the result register is empty or its result is taken in the same cycle, so
// the sustained rate is one transaction per cycle and only result back
// pressure slows it. After reset the block is waiting with position and tick
// count at zero; once found or timed out it holds until a restart.
`include "response_string_matcher_with_timeout_defines.svh"

module response_string_matcher_with_timeout
  import rsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rsm_in_if.sink    in_i,
  rsm_out_if.source out_o,
  rsm_cfg_if.sink   cfg_i
);

  rsm_cfg_t          cfg;
  logic [LEN_W-1:0]  eff_len;
  logic              in_accept;

  logic [LEN_W-1:0]  matched_q, matched_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  status_e           status_q, status_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [LEN_W-1:0]  out_pos_q;

  logic              expired;
  logic [TICK_W-1:0] elapsed_inc;
  logic [LEN_W-1:0]  pos, pos_next;

  rsm_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign eff_len    = effective_length(cfg.length);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    matched_d = matched_q;
    elapsed_d = elapsed_q;
    status_d  = status_q;

    expired     = (elapsed_q >= cfg.timeout);
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);

    // A position left at or beyond a shortened length starts over.
    pos = (matched_q >= eff_len) ? '0 : matched_q;
    // On a mismatch the byte may still open a new match at the first character.
    if (in_i.rx_byte == cfg.chars[pos[CHAR_IDX_W-1:0]]) begin
      pos_next = pos + LEN_W'(1);
    end else if (in_i.rx_byte == cfg.chars[0]) begin
      pos_next = LEN_W'(1);
    end else begin
      pos_next = '0;
    end

    case (in_i.cmd)
      CMD_RESTART: begin
        matched_d = '0;
        elapsed_d = '0;
        status_d  = (cfg.timeout == '0) ? ST_TIMEOUT : ST_WAITING;
      end
      CMD_BYTE: begin
        if (status_q == ST_WAITING) begin
          if (expired) begin
            status_d = ST_TIMEOUT;
          end else begin
            matched_d = pos_next;
            if (pos_next >= eff_len) begin
              status_d = ST_FOUND;
            end
          end
        end
      end
      CMD_TICK: begin
        if (status_q == ST_WAITING) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= cfg.timeout) begin
            status_d = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= '0;
      elapsed_q <= '0;
      status_q  <= ST_WAITING;
    end else if (in_accept) begin
      matched_q <= matched_d;
      elapsed_q <= elapsed_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_status_q <= status_d;
      out_pos_q    <= matched_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.match_position = out_pos_q;

  `RSM_ASSERT_IMPL(a_found_has_match, status_q == ST_FOUND, matched_q != '0,
                   "found with no characters matched")
  `RSM_ASSERT_NEXT(a_restart_clears, in_accept && in_i.cmd == CMD_RESTART,
                   matched_q == '0 && elapsed_q == '0,
                   "restart did not clear position and ticks")
  `RSM_ASSERT_NEXT(a_outcome_holds,
                   in_accept && status_q != ST_WAITING && in_i.cmd != CMD_RESTART,
                   status_q == $past(status_q) && matched_q == $past(matched_q),
                   "status changed without a restart")
  `RSM_ASSERT_IMPL(a_ready_when_empty, !out_valid_q, in_i.ready,
                   "input stalled with an empty result register")
  `RSM_ASSERT(a_position_bound, 32'(matched_q) <= MAX_PATTERN_CHARS,
              "match position beyond the longest pattern")

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Response string matcher testbench
// Feeds byte, tick and restart transactions through the input channel, models
// the match position, the tick count and the wait status, and checks every
// report on the result channel in order. Rounds vary the pattern, its length,
// the timeout, and the idle and stall rates of both channels.
// -----------------------------------------------------------------------------
module tb_top;
  import rsm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ROUNDS = 12;
  localparam int ROUND_ITEMS = 40;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } feed_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] position;
  } report_t;

  logic clk;
  logic rst_n;

  rsm_in_if  in_ch ();
  rsm_out_if out_ch ();
  rsm_cfg_if cfg_ch ();

  response_string_matcher_with_timeout dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  feed_t   rx_feed[$];
  report_t expected_reports[$];
  feed_t   next_feed;
  feed_t   seen_feed;
  report_t want;
  bit      in_taken;
  int      send_idle_pct;
  int      stall_pct;
  int      errors;
  int      items_accepted;
  int      reports_checked;
  int      found_seen;
  int      timeouts_seen;
  int      round_items;

  // Local copy of the configuration and of the matcher state.
  logic [15:0][7:0] m_chars;
  logic [4:0]       m_len_reg;
  logic [31:0]      m_timeout;
  logic [4:0]       m_pos;
  logic [31:0]      m_elapsed;
  status_e          m_status;

  function automatic int unsigned active_length();
    if (m_len_reg == 5'd0) begin
      return 1;
    end else if (m_len_reg > 5'd16) begin
      return 16;
    end
    return m_len_reg;
  endfunction

  function automatic report_t advance_matcher(input feed_t f);
    int unsigned len;
    logic [4:0]  p;
    report_t     r;
    len = active_length();
    if (f.cmd == CMD_RESTART) begin
      m_pos     = 5'd0;
      m_elapsed = 32'd0;
      m_status  = (m_timeout == 32'd0) ? ST_TIMEOUT : ST_WAITING;
    end else if (m_status == ST_WAITING && f.cmd == CMD_BYTE) begin
      if (m_elapsed >= m_timeout) begin
        // The byte arrives after the deadline and is dropped.
        m_status = ST_TIMEOUT;
      end else begin
        p = m_pos;
        if (p >= len) begin
          p = 5'd0;
        end
        if (f.data == m_chars[p[3:0]]) begin
          p = p + 5'd1;
        end else if (f.data == m_chars[0]) begin
          p = 5'd1;
        end else begin
          p = 5'd0;
        end
        m_pos = p;
        if (p >= len) begin
          m_status = ST_FOUND;
        end
      end
    end else if (m_status == ST_WAITING && f.cmd == CMD_TICK) begin
      if (m_elapsed != 32'hFFFF_FFFF) begin
        m_elapsed = m_elapsed + 32'd1;
      end
      if (m_elapsed >= m_timeout) begin
        m_status = ST_TIMEOUT;
      end
    end
    r.status   = m_status;
    r.position = m_pos;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input driver: a transaction is held until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (rx_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_feed = rx_feed.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= next_feed.cmd;
        in_ch.rx_byte <= next_feed.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predicts on every accepted input and checks every report.
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      seen_feed = {in_ch.cmd, in_ch.rx_byte};
      expected_reports.push_back(advance_matcher(seen_feed));
      items_accepted++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report: status %0d position %0d", $time,
                 out_ch.status, out_ch.match_position);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (out_ch.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   want.status, out_ch.status);
          errors++;
        end
        if (out_ch.match_position !== want.position) begin
          $display("%0t: match position mismatch: expected %0d, actual %0d", $time,
                   want.position, out_ch.match_position);
          errors++;
        end
        if (want.status == ST_FOUND) begin
          found_seen++;
        end else if (want.status == ST_TIMEOUT) begin
          timeouts_seen++;
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PAT_LOW:  m_chars[7:0]  = value;
      REG_PAT_HIGH: m_chars[15:8] = value;
      REG_LENGTH:   m_len_reg     = value[4:0];
      REG_TIMEOUT:  m_timeout     = value[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Returns once nothing is queued, in flight or awaiting its report.
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (rx_feed.size() != 0 || in_ch.valid || expected_reports.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic push_feed(input logic [1:0] cmd, input logic [7:0] data);
    rx_feed.push_back({cmd, data});
    round_items++;
  endtask

  function automatic logic [7:0] pick_char(input int unsigned alpha);
    if (alpha == 0) begin
      return 8'($urandom_range(255));
    end
    return 8'h61 + 8'($urandom_range(alpha - 1));
  endfunction

  task automatic push_noise();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      push_feed(CMD_TICK, 8'($urandom));
    end else if (pick < 8) begin
      push_feed(CMD_BYTE, m_chars[$urandom_range(active_length() - 1)]);
    end else begin
      push_feed(CMD_BYTE, 8'($urandom));
    end
  endtask

  // Mostly a restart followed by the pattern with noise mixed in; some
  // sessions skip the restart or are random traffic of every command.
  task automatic queue_session();
    int unsigned len;
    int unsigned k;
    len = active_length();
    if ($urandom_range(99) < 85) begin
      push_feed(CMD_RESTART, 8'($urandom));
    end
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 10)) push_feed(2'($urandom_range(3)), 8'($urandom));
    end else begin
      for (k = 0; k < len; k++) begin
        while ($urandom_range(99) < 20) push_noise();
        push_feed(CMD_BYTE, m_chars[k]);
      end
      repeat ($urandom_range(2)) push_feed(2'($urandom_range(3)), 8'($urandom));
    end
  endtask

  task automatic setup_round(input int r);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    logic [63:0] tmo_word;
    int unsigned alpha;
    int          i;
    alpha = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 4);
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_char(alpha);
      hi[8*i +: 8] = pick_char(alpha);
    end
    len_word = {$urandom, $urandom};
    case (r)
      0:       len_word[4:0] = 5'd1;
      1:       len_word[4:0] = 5'd16;
      2:       len_word[4:0] = 5'd31;
      3:       len_word[4:0] = 5'd0;
      default: len_word[4:0] = 5'($urandom_range(1, 16));
    endcase
    tmo_word = {$urandom, $urandom};
    if (r == 4) begin
      tmo_word[31:0] = 32'hFFFF_FFFF;
    end else if (r == 5) begin
      tmo_word[31:0] = 32'd0;
    end else begin
      tmo_word[31:0] = 32'($urandom_range(1, 6));
    end
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_LENGTH, len_word);
    write_reg(REG_TIMEOUT, tmo_word);
  endtask

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_BYTE;
    in_ch.rx_byte    = 8'd0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_PAT_LOW;
    cfg_ch.data      = 64'd0;
    rst_n            = 1'b0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    m_chars          = '0;
    m_len_reg        = 5'd1;
    m_timeout        = 32'd0;
    m_pos            = 5'd0;
    m_elapsed        = 32'd0;
    m_status         = ST_WAITING;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // With the reset timeout of zero, a byte before any restart times out.
    push_feed(CMD_BYTE, 8'h00);
    push_feed(CMD_UNUSED, 8'hFF);
    wait_idle();

    write_reg(REG_PAT_LOW, 64'h4847_4645_4443_4241);
    write_reg(REG_PAT_HIGH, 64'hFF00_4E4D_4C4B_4A49);
    write_reg(REG_LENGTH, 64'd16);
    write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
    push_feed(CMD_RESTART, 8'h00);
    for (int k = 0; k < 5; k++) push_feed(CMD_BYTE, m_chars[k]);
    push_feed(CMD_TICK, 8'h00);
    wait_idle();

    // Shortening the pattern below the current position restarts the match.
    write_reg(REG_LENGTH, 64'd3);
    for (int k = 0; k < 4; k++) push_feed(CMD_BYTE, m_chars[k]);
    wait_idle();

    write_reg(REG_LENGTH, 64'd0);
    write_reg(REG_TIMEOUT, 64'd3);
    push_feed(CMD_RESTART, 8'h00);
    push_feed(CMD_BYTE, m_chars[0]);
    push_feed(CMD_RESTART, 8'h00);
    push_feed(CMD_TICK, 8'h00);
    push_feed(CMD_TICK, 8'h00);
    wait_idle();

    // Lowering the timeout below the elapsed count drops the next byte.
    write_reg(REG_TIMEOUT, 64'd1);
    push_feed(CMD_BYTE, 8'hFF);
    wait_idle();

    write_reg(REG_TIMEOUT, 64'd0);
    push_feed(CMD_RESTART, 8'h00);
    wait_idle();

    for (int r = 0; r < ROUNDS; r++) begin
      case (r % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      setup_round(r);
      round_items = 0;
      while (round_items < ROUND_ITEMS) queue_session();
      wait_idle();
    end
    repeat (4) @(negedge clk);

    $display("Accepted %0d input transactions and checked %0d reports over %0d rounds.",
             items_accepted, reports_checked, ROUNDS);
    $display("Reports showing a found response: %0d, showing a timeout: %0d.",
             found_seen, timeouts_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/rsm_pkg.sv
hdl/rsm_if.sv
hdl/rsm_cfg_regs.sv
hdl/response_string_matcher_with_timeout.sv
test/tb_top.sv
